// File: hw/rtl/ajb_pkg.sv
// Shared types and constants for the audio jitter buffer.
`default_nettype none

package ajb_pkg;

    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;

    typedef enum logic [0:0] {
        FUNC_PUSH = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef struct packed {
        logic push;
        logic tick;
        logic fetch;
    } cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/audio_jitter_buffer_top.sv
// Top level of the audio jitter buffer.
//
//  channel  dir  tdata                 tuser                      tlast
//  s_axis   in   [7:0] data_byte       [0] func (0 push, 1 tick)  -
//  m_axis   out  [15:0] sample (Q1.15) [0] playing, [1] dropped   last sample
//
// Pushes are taken back to back.
// A tick request yields BLOCK_SAMPLES results; each is a ring read of two bytes
// (fetch state) followed by an output state that holds through any output stall.
// No request is taken while a block is being played out.
// Reset clears pointers, fill count and flags; ring contents are not cleared.
`default_nettype none

module audio_jitter_buffer_top #(
    parameter int BLOCK_SAMPLES = 32,
    parameter int RING_BYTES    = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] func
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [15:0] m_axis_tdata,   // [15:0] sample
    output      logic [1:0]  m_axis_tuser,   // [0] playing, [1] dropped
    output      logic        m_axis_tlast
);

    ajb_pkg::cmd_t                       cmd;
    logic signed [ajb_pkg::SAMPLE_W-1:0] sample;
    logic                                playing;
    logic                                dropped;

    ajb_ctrl #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_last  (m_axis_tlast),
        .cmd       (cmd)
    );

    ajb_datapath #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES),
        .RING_BYTES    (RING_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (s_axis_tdata),
        .sample    (sample),
        .playing   (playing),
        .dropped   (dropped)
    );

    assign m_axis_tdata = sample;
    assign m_axis_tuser = {dropped, playing};

endmodule

`default_nettype wire

// File: hw/rtl/ajb_ctrl.sv
// Sequencer for request intake and block playout.
`default_nettype none

module ajb_ctrl #(
    parameter int BLOCK_SAMPLES = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output      logic         in_ready,
    input  wire logic         in_func,
    output      logic         out_valid,
    input  wire logic         out_ready,
    output      logic         out_last,
    output      ajb_pkg::cmd_t cmd
);

    localparam int CNT_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_SEND  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_acc;
    logic             out_acc;
    logic             at_last;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_SEND);
    assign in_acc    = in_valid & in_ready;
    assign out_acc   = out_valid & out_ready;
    assign at_last   = (cnt_reg == CNT_W'(BLOCK_SAMPLES - 1));
    assign out_last  = at_last;

    always_comb
    begin
        cmd.push  = in_acc & (in_func == ajb_pkg::FUNC_PUSH);
        cmd.tick  = in_acc & (in_func == ajb_pkg::FUNC_TICK);
        cmd.fetch = (state_reg == ST_FETCH);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.tick)
                begin
                    state_next = ST_FETCH;
                    cnt_next   = '0;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_acc)
                begin
                    if (at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                        cnt_next   = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ajb_datapath.sv
// Byte ring, pointers, fill count and sample assembly.
`default_nettype none

module ajb_datapath #(
    parameter int BLOCK_SAMPLES = 32,
    parameter int RING_BYTES    = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ajb_pkg::cmd_t                       cmd,
    input  wire logic [ajb_pkg::BYTE_W-1:0]          data_byte,
    output      logic signed [ajb_pkg::SAMPLE_W-1:0] sample,
    output      logic                                playing,
    output      logic                                dropped
);

    localparam int PTR_W  = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
    localparam int FILL_W = $clog2(RING_BYTES + 1);
    localparam int BW     = ajb_pkg::BYTE_W;

    logic [BW-1:0]     ring_mem [RING_BYTES];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              drop_reg, drop_next;
    logic              play_reg, play_next;
    logic              blk_drop_reg, blk_drop_next;
    logic [BW-1:0]     lo_reg;
    logic [BW-1:0]     hi_reg;
    logic [PTR_W-1:0]  wr_inc;
    logic [PTR_W-1:0]  rd_p1;
    logic [PTR_W-1:0]  rd_p2;
    logic              full;
    logic              enough;
    logic              store;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_inc = ring_next(wr_reg);
    assign rd_p1  = ring_next(rd_reg);
    assign rd_p2  = ring_next(rd_p1);
    assign full   = (fill_reg == FILL_W'(RING_BYTES));
    assign enough = ({{(32 - FILL_W){1'b0}}, fill_reg} >= 32'(2 * BLOCK_SAMPLES));
    assign store  = cmd.push & ~full;

    always_comb
    begin
        wr_next       = wr_reg;
        rd_next       = rd_reg;
        fill_next     = fill_reg;
        drop_next     = drop_reg;
        play_next     = play_reg;
        blk_drop_next = blk_drop_reg;
        if (cmd.push)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                wr_next   = wr_inc;
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        if (cmd.tick)
        begin
            blk_drop_next = drop_reg;
            drop_next     = 1'b0;
            play_next     = enough;
        end
        if (cmd.fetch && play_reg)
        begin
            rd_next   = rd_p2;
            fill_next = fill_reg - FILL_W'(2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            ring_mem[wr_reg] <= data_byte;
        end
        if (cmd.fetch)
        begin
            lo_reg <= ring_mem[rd_reg];
            hi_reg <= ring_mem[rd_p1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg       <= '0;
            rd_reg       <= '0;
            fill_reg     <= '0;
            drop_reg     <= 1'b0;
            play_reg     <= 1'b0;
            blk_drop_reg <= 1'b0;
        end
        else
        begin
            wr_reg       <= wr_next;
            rd_reg       <= rd_next;
            fill_reg     <= fill_next;
            drop_reg     <= drop_next;
            play_reg     <= play_next;
            blk_drop_reg <= blk_drop_next;
        end
    end

    assign sample  = play_reg ? $signed({hi_reg, lo_reg}) : '0;
    assign playing = play_reg;
    assign dropped = blk_drop_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ajb_checker.sv
// Port-level checks for the audio jitter buffer, bound to the top level.
`default_nettype none

module ajb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    a_no_request_while_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready
    ) else $error("request taken while a result is pending");

    a_tick_starts_block: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready ##1 m_axis_tvalid
    ) else $error("tick did not start a block");

    a_silent_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 16'h0000)
    ) else $error("nonzero sample while not playing");

    a_hold_stalled: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast))
    ) else $error("stalled result changed");

endmodule

bind audio_jitter_buffer_top ajb_checker u_ajb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
